// ===== sv/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Types, constants and scaling helpers shared by the touch coordinate
// conditioner modules.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // converter resolution; raw fields are masked to their low AdcBits bits
   localparam int AdcBits = 12;
   localparam int RawW    = 12;
   localparam logic [RawW-1:0] RawMask =
      (AdcBits >= RawW) ? {RawW{1'b1}} : RawW'((1 << AdcBits) - 1);

   localparam int HeldXW = 8;
   localparam int HeldYW = 9;
   localparam int ScrW   = 9;

   // X scaling: piecewise offset, then divide by 15
   localparam logic [RawW-1:0] XKnee      = 12'd3000;
   localparam logic [RawW-1:0] XOffsetLo  = 12'd3900;
   localparam logic [RawW-1:0] XOffsetHi  = 12'd3800;
   localparam logic [12:0]     XRecip     = 13'd4370;   // ceil(2^16 / 15)
   localparam logic [8:0]      XMax       = 9'd239;

   // Y scaling: subtract 360, then divide by 11
   localparam logic [RawW-1:0] YOffset    = 12'd360;
   localparam logic [12:0]     YRecip     = 13'd5958;   // ceil(2^16 / 11)
   localparam logic [8:0]      YLimit     = 9'd320;
   localparam logic [8:0]      YMax       = 9'd319;

   localparam logic [ScrW-1:0] PortraitXMax  = 9'd239;
   localparam logic [ScrW-1:0] PortraitYMax  = 9'd319;
   localparam logic [ScrW-1:0] LandscapeXMax = 9'd319;
   localparam logic [ScrW-1:0] LandscapeYMax = 9'd239;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // configuration register indexes
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 4;
   localparam logic [CsrIdxW-1:0] CSR_ORIENTATION = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_DEAD_ZONE   = 1'b1;

   localparam logic [3:0] DeadZoneReset = 4'd4;

   typedef enum logic [1:0] {
      ORIENT_PORTRAIT_MIRROR = 2'd0,
      ORIENT_PORTRAIT        = 2'd1,
      ORIENT_LANDSCAPE_MIRX  = 2'd2,
      ORIENT_LANDSCAPE_MIRY  = 2'd3
   } orient_type;

   typedef struct packed {
      logic            touch_detected;
      logic [RawW-1:0] raw_x;
      logic [RawW-1:0] raw_y;
   } req_type;

   typedef struct packed {
      logic            pressed;
      logic            was_pressed;
      logic [ScrW-1:0] screen_x;
      logic [ScrW-1:0] screen_y;
   } rsp_type;

   // scaled, unoriented sample carried from front to back
   typedef struct packed {
      logic              touch;
      logic [HeldXW-1:0] x;
      logic [HeldYW-1:0] y;
   } scaled_type;

   typedef struct packed {
      orient_type orientation;
      logic [3:0] dead_zone;
   } cfg_type;

   // queue status toward the back end
   typedef struct packed {
      logic       valid;
      scaled_type data;
   } q_head_type;

endpackage

// ===== sv/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Accepts raw samples and scales each axis to an unoriented panel
// coordinate, pushing the result into the queue.
// ----------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; (
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  logic       q_full,
   output logic       q_push,
   output scaled_type q_push_data
);

   logic [RawW-1:0] rx;
   logic [RawW-1:0] ry;
   logic [RawW-1:0] dx;
   logic [RawW-1:0] dy;
   logic [24:0]     px;
   logic [24:0]     py;
   logic [8:0]      qx;
   logic [8:0]      qy;
   logic [8:0]      cx;
   logic [8:0]      cy;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      rx = req_data.raw_x & RawMask;
      ry = req_data.raw_y & RawMask;

      // negative offsets clamp to zero before the divide
      if (rx <= XKnee) begin
         dx = XOffsetLo - rx;
      end else if (rx < XOffsetHi) begin
         dx = XOffsetHi - rx;
      end else begin
         dx = '0;
      end

      if (ry > YOffset) begin
         dy = ry - YOffset;
      end else begin
         dy = '0;
      end

      // reciprocal divide, exact for 12-bit dividends
      px = 25'(dx) * 25'(XRecip);
      py = 25'(dy) * 25'(YRecip);
      qx = px[24:16];
      qy = py[24:16];

      cx = (qx > XMax) ? XMax : qx;
      cy = (qy >= YLimit) ? YMax : qy;

      q_push_data.touch = req_data.touch_detected;
      q_push_data.x     = cx[HeldXW-1:0];
      q_push_data.y     = cy;
   end

endmodule

// ===== sv/tcc_queue.sv =====
// ----------------------------------------------------------------------------
// tcc_queue
// Short flop-based FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module tcc_queue import tcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  scaled_type push_data,
   output logic       full,
   input  logic       pop,
   output q_head_type head
);

   scaled_type               mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]     count_ff, count_in;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// Applies the dead zone against the held coordinates, orients them, decides
// pressed and holds the result in the output register.
// ----------------------------------------------------------------------------
module tcc_back import tcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  q_head_type head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic [HeldXW-1:0] held_x_ff, held_x_in;
   logic [HeldYW-1:0] held_y_ff, held_y_in;
   logic              pressed_ff, pressed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [HeldXW-1:0] diff_x;
   logic [HeldYW-1:0] diff_y;
   logic [ScrW-1:0]   sx;
   logic [ScrW-1:0]   sy;
   logic [ScrW-1:0]   x_lim;
   logic [ScrW-1:0]   y_lim;
   logic              portrait;

   assign pop       = head.valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      diff_x = (head.data.x > held_x_ff) ? head.data.x - held_x_ff : held_x_ff - head.data.x;
      diff_y = (head.data.y > held_y_ff) ? head.data.y - held_y_ff : held_y_ff - head.data.y;

      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      if (head.data.touch) begin
         if (diff_x > HeldXW'(cfg.dead_zone)) begin
            held_x_in = head.data.x;
         end
         if (diff_y > HeldYW'(cfg.dead_zone)) begin
            held_y_in = head.data.y;
         end
      end

      case (cfg.orientation)
         ORIENT_PORTRAIT_MIRROR: begin
            sx = PortraitXMax - ScrW'(held_x_in);
            sy = PortraitYMax - held_y_in;
         end
         ORIENT_PORTRAIT: begin
            sx = ScrW'(held_x_in);
            sy = held_y_in;
         end
         ORIENT_LANDSCAPE_MIRX: begin
            sx = LandscapeXMax - held_y_in;
            sy = ScrW'(held_x_in);
         end
         default: begin
            sx = held_y_in;
            sy = LandscapeYMax - ScrW'(held_x_in);
         end
      endcase

      portrait = (cfg.orientation == ORIENT_PORTRAIT_MIRROR) ||
                 (cfg.orientation == ORIENT_PORTRAIT);
      x_lim    = portrait ? PortraitXMax : LandscapeXMax;
      y_lim    = portrait ? PortraitYMax : LandscapeYMax;

      pressed_in = head.data.touch && (sx != '0) && (sx < x_lim) &&
                   (sy != '0) && (sy < y_lim);

      rsp_in.pressed     = pressed_in;
      rsp_in.was_pressed = pressed_ff;
      rsp_in.screen_x    = sx;
      rsp_in.screen_y    = sy;

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         pressed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            held_x_ff  <= held_x_in;
            held_y_ff  <= held_y_in;
            pressed_ff <= pressed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   // held values only ever come from clamped scaler outputs
   a_held_x_range: assert property (@(posedge clock) disable iff (reset)
      held_x_ff <= HeldXW'(XMax))
      else $error("held_x out of range");

   a_held_y_range: assert property (@(posedge clock) disable iff (reset)
      held_y_ff <= YMax)
      else $error("held_y out of range");

   // a popped sample always lands in the output register
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped sample not presented");

   // reported press history tracks the previous press decision
   a_was_pressed: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_ff.was_pressed == $past(pressed_ff)) && (pressed_ff == rsp_ff.pressed))
      else $error("press history mismatch");

endmodule

// ===== sv/touch_coordinate_conditioner.sv =====
// ----------------------------------------------------------------------------
// touch_coordinate_conditioner
// Converts raw touch samples into debounced, oriented screen coordinates.
//
// Request channel (req_valid / req_stall / req_data): one touch sample per
// accepted request, taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one result per
// request, in order. A result reaches rsp_data by a queue write, then an
// output register load, which rsp_stall can hold off.
// Throughput is one request per cycle while rsp_stall is low: the front end
// scales and pushes into a two-entry queue, the back end pops one sample per
// cycle, updates the held coordinates and loads the output register.
// When rsp_stall is high the output register holds; the queue fills and then
// req_stall rises, so at most three requests are in flight.
// Configuration (csr_valid / csr_ready / csr_index / csr_wdata) is always
// ready; index 0 is orientation, index 1 the dead zone. Write it only while
// no results are pending.
// Reset (synchronous, active high) empties the queue, clears held
// coordinates and press history, and sets orientation 0, dead zone 4.
// ----------------------------------------------------------------------------
module touch_coordinate_conditioner import tcc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       q_full;
   logic       q_push;
   logic       q_pop;
   scaled_type q_push_data;
   q_head_type q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIENTATION: cfg_in.orientation = orient_type'(csr_wdata[1:0]);
            CSR_DEAD_ZONE:   cfg_in.dead_zone   = csr_wdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation <= ORIENT_PORTRAIT_MIRROR;
         cfg_ff.dead_zone   <= DeadZoneReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcc_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   tcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   tcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
